// ===== hw/rtl/scc_pkg.sv =====
// shared types, constants and arctangent table for the spherical coordinate converter
package scc_pkg;

   localparam int COORD_W       = 32;
   localparam int RADIUS_W      = COORD_W - 1;
   localparam int ANG_IO_W      = 32;
   localparam int GUARD_BITS    = 60 - COORD_W;
   localparam int LEN_W         = 64;
   localparam int ANG_W         = 36;
   localparam int CORDIC_STAGES = 28;
   localparam int IDX_W         = $clog2(CORDIC_STAGES);
   localparam int GAIN_W        = 30;

   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

   localparam logic signed [ANG_W-1:0] PI_Q32      = 36'sh3243F6A89;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 36'sh1921FB544;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q32  = 36'sh6487ED511;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_UNDEF = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic MODE_TO_POLAR = 1'b0;
   localparam logic MODE_TO_CART  = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
      logic [RADIUS_W-1:0]        radius;
      logic signed [ANG_IO_W-1:0] horiz_angle;
      logic signed [ANG_IO_W-1:0] vert_angle;
   } scc_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  res_x;
      logic signed [COORD_W-1:0]  res_y;
      logic signed [COORD_W-1:0]  res_z;
      logic [RADIUS_W-1:0]        res_radius;
      logic signed [ANG_IO_W-1:0] res_horiz_angle;
      logic signed [ANG_IO_W-1:0] res_vert_angle;
      logic [1:0]                 status;
   } scc_rsp_type;

   typedef struct packed {
      scc_req_type             req;
      logic                    neg_h;
      logic signed [ANG_W-1:0] aux_ang;
      logic signed [LEN_W-1:0] aux_len;
   } scc_side_type;

   typedef struct packed {
      logic signed [LEN_W-1:0] x;
      logic signed [LEN_W-1:0] y;
      logic signed [ANG_W-1:0] ang;
      scc_side_type            side;
   } scc_data_type;

   function automatic logic signed [ANG_W-1:0] atan_q32(input logic [IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:    val = 36'sd3373259426;
         5'd1:    val = 36'sd1991351318;
         5'd2:    val = 36'sd1052175346;
         5'd3:    val = 36'sd534100635;
         5'd4:    val = 36'sd268086748;
         5'd5:    val = 36'sd134174063;
         5'd6:    val = 36'sd67103403;
         5'd7:    val = 36'sd33553749;
         5'd8:    val = 36'sd16777131;
         5'd9:    val = 36'sd8388597;
         5'd10:   val = 36'sd4194303;
         default: val = 36'sd1 <<< (6'd32 - {1'b0, idx});
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/spherical_coord_converter_core.sv =====
// top level: Cartesian/spherical converter built from two unrolled cordic pipelines
// Takes one item per clock (busy is never raised) and returns its result on
// rsp_valid after one setup stage, 28 cordic stages, three gain
// stages, one hand-over stage, 28 cordic stages, three gain stages and the output
// register. The result is shown for one cycle only; there is no back-pressure.
module spherical_coord_converter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  scc_pkg::scc_req_type req_item,
   output logic                 rsp_valid,
   output scc_pkg::scc_rsp_type rsp_item
);

   localparam int NS = scc_pkg::CORDIC_STAGES;

   function automatic logic signed [scc_pkg::ANG_W-1:0] fold(
      input logic signed [scc_pkg::ANG_W-1:0] a, output logic neg);
      logic signed [scc_pkg::ANG_W-1:0] v;
      v   = a;
      neg = 1'b0;
      if (v >= scc_pkg::PI_Q32) v = v - scc_pkg::TWO_PI_Q32;
      if (v < -scc_pkg::PI_Q32) v = v + scc_pkg::TWO_PI_Q32;
      if (v > scc_pkg::HALF_PI_Q32) begin
         v   = v - scc_pkg::PI_Q32;
         neg = 1'b1;
      end else if (v < -scc_pkg::HALF_PI_Q32) begin
         v   = v + scc_pkg::PI_Q32;
         neg = 1'b1;
      end
      return v;
   endfunction

   function automatic logic signed [scc_pkg::ANG_W-1:0] clamp(
      input logic signed [scc_pkg::ANG_W-1:0] a);
      logic signed [scc_pkg::ANG_W-1:0] v;
      v = a;
      if (a > scc_pkg::HALF_PI_Q32) v = scc_pkg::HALF_PI_Q32;
      if (a < -scc_pkg::HALF_PI_Q32) v = -scc_pkg::HALF_PI_Q32;
      return v;
   endfunction

   function automatic logic [scc_pkg::ANG_IO_W-1:0] angle_out(
      input logic signed [scc_pkg::ANG_W-1:0] a);
      logic signed [scc_pkg::ANG_W-1:0] r;
      r = (a + 36'sd8) >>> 4;
      return r[scc_pkg::ANG_IO_W-1:0];
   endfunction

   function automatic logic [scc_pkg::COORD_W-1:0] coord_out(
      input logic signed [scc_pkg::LEN_W-1:0] v, output logic sat);
      logic signed [scc_pkg::LEN_W-1:0] r;
      logic [scc_pkg::COORD_W-1:0]      o;
      r   = (v + (64'sd1 <<< (scc_pkg::GUARD_BITS - 1))) >>> scc_pkg::GUARD_BITS;
      sat = 1'b0;
      o   = r[scc_pkg::COORD_W-1:0];
      if (r > (64'sd1 <<< (scc_pkg::COORD_W - 1)) - 64'sd1) begin
         o   = {1'b0, {(scc_pkg::COORD_W-1){1'b1}}};
         sat = 1'b1;
      end
      if (r < -(64'sd1 <<< (scc_pkg::COORD_W - 1))) begin
         o   = {1'b1, {(scc_pkg::COORD_W-1){1'b0}}};
         sat = 1'b1;
      end
      return o;
   endfunction

   // setup stage
   logic                  prep_valid_ff;
   scc_pkg::scc_data_type prep_ff, prep_in;

   always_comb begin
      logic signed [scc_pkg::COORD_W:0] ax, bz;
      logic signed [scc_pkg::ANG_W-1:0] va, ha;
      logic                             nv, nh;
      logic signed [scc_pkg::LEN_W-1:0] r;
      ax = req_item.coord_x[scc_pkg::COORD_W-1] ? -(scc_pkg::COORD_W+1)'(req_item.coord_x)
                                               : (scc_pkg::COORD_W+1)'(req_item.coord_x);
      bz = req_item.coord_x[scc_pkg::COORD_W-1] ? -(scc_pkg::COORD_W+1)'(req_item.coord_z)
                                               : (scc_pkg::COORD_W+1)'(req_item.coord_z);
      va = fold({req_item.vert_angle, 4'b0}, nv);
      ha = fold({req_item.horiz_angle, 4'b0}, nh);
      r  = scc_pkg::LEN_W'(req_item.radius) <<< scc_pkg::GUARD_BITS;
      prep_in.side.req     = req_item;
      prep_in.side.neg_h   = nh;
      prep_in.side.aux_ang = ha;
      prep_in.side.aux_len = '0;
      if (req_item.req_type == scc_pkg::MODE_TO_CART) begin
         prep_in.x   = nv ? -r : r;
         prep_in.y   = '0;
         prep_in.ang = va;
      end else begin
         prep_in.x   = scc_pkg::LEN_W'(ax) <<< scc_pkg::GUARD_BITS;
         prep_in.y   = scc_pkg::LEN_W'(bz) <<< scc_pkg::GUARD_BITS;
         prep_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= start;
      end
      prep_ff <= prep_in;
   end

   // first cordic
   logic                  c1_valid [0:NS];
   scc_pkg::scc_data_type c1_data  [0:NS];
   assign c1_valid[0] = prep_valid_ff;
   assign c1_data[0]  = prep_ff;

   for (genvar i = 0; i < NS; i++) begin : g_c1
      scc_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (scc_pkg::IDX_W'(i)),
         .in_valid  (c1_valid[i]),
         .in_data   (c1_data[i]),
         .out_valid (c1_valid[i+1]),
         .out_data  (c1_data[i+1])
      );
   end

   logic                  g1_valid;
   scc_pkg::scc_data_type g1_data;

   scc_gain u_gain1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid[NS]),
      .in_data   (c1_data[NS]),
      .out_valid (g1_valid),
      .out_data  (g1_data)
   );

   // hand-over between the two cordics
   logic                  mid_valid_ff;
   scc_pkg::scc_data_type mid_ff, mid_in;

   always_comb begin
      mid_in = g1_data;
      if (g1_data.side.req.req_type == scc_pkg::MODE_TO_CART) begin
         mid_in.x            = g1_data.side.neg_h ? -g1_data.x : g1_data.x;
         mid_in.y            = '0;
         mid_in.ang          = g1_data.side.aux_ang;
         mid_in.side.aux_len = g1_data.y;
      end else begin
         mid_in.x            = g1_data.x;
         mid_in.y            = scc_pkg::LEN_W'(g1_data.side.req.coord_y) <<< scc_pkg::GUARD_BITS;
         mid_in.ang          = '0;
         mid_in.side.aux_ang = g1_data.ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= g1_valid;
      end
      mid_ff <= mid_in;
   end

   // second cordic
   logic                  c2_valid [0:NS];
   scc_pkg::scc_data_type c2_data  [0:NS];
   assign c2_valid[0] = mid_valid_ff;
   assign c2_data[0]  = mid_ff;

   for (genvar i = 0; i < NS; i++) begin : g_c2
      scc_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (scc_pkg::IDX_W'(i)),
         .in_valid  (c2_valid[i]),
         .in_data   (c2_data[i]),
         .out_valid (c2_valid[i+1]),
         .out_data  (c2_data[i+1])
      );
   end

   logic                  g2_valid;
   scc_pkg::scc_data_type g2_data;

   scc_gain u_gain2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2_valid[NS]),
      .in_data   (c2_data[NS]),
      .out_valid (g2_valid),
      .out_data  (g2_data)
   );

   // output stage
   logic                 out_valid_ff;
   scc_pkg::scc_rsp_type out_ff, out_in;

   always_comb begin
      scc_pkg::scc_req_type             rq;
      logic [scc_pkg::LEN_W-1:0]        nr;
      logic signed [scc_pkg::ANG_W-1:0] h, v;
      logic                             undef, sat, sx, sy, sz;
      rq    = g2_data.side.req;
      nr    = (unsigned'(g2_data.x) + (64'd1 << (scc_pkg::GUARD_BITS - 1)))
              >> scc_pkg::GUARD_BITS;
      undef = (rq.coord_x == '0) && (rq.coord_z == '0);
      h     = '0;
      v     = '0;
      sat   = 1'b0;
      sx    = 1'b0;
      sy    = 1'b0;
      sz    = 1'b0;
      out_in = '0;
      if (rq.req_type == scc_pkg::MODE_TO_CART) begin
         out_in.res_x           = coord_out(g2_data.x, sx);
         out_in.res_y           = coord_out(g2_data.side.aux_len, sy);
         out_in.res_z           = coord_out(g2_data.y, sz);
         out_in.res_radius      = rq.radius;
         out_in.res_horiz_angle = rq.horiz_angle;
         out_in.res_vert_angle  = rq.vert_angle;
         out_in.status          = (sx | sy | sz) ? scc_pkg::STATUS_SAT : scc_pkg::STATUS_OK;
      end else begin
         // on-axis cases get exact angles
         if (rq.coord_x == '0) begin
            if (rq.coord_z[scc_pkg::COORD_W-1]) h = -scc_pkg::HALF_PI_Q32;
            else if (rq.coord_z != '0) h = scc_pkg::HALF_PI_Q32;
         end else begin
            h = clamp(g2_data.side.aux_ang);
            if (rq.coord_x[scc_pkg::COORD_W-1]) h = h + scc_pkg::PI_Q32;
         end
         if (undef) begin
            if (rq.coord_y[scc_pkg::COORD_W-1]) v = -scc_pkg::HALF_PI_Q32;
            else if (rq.coord_y != '0) v = scc_pkg::HALF_PI_Q32;
         end else begin
            v = clamp(g2_data.ang);
         end
         sat = nr > scc_pkg::LEN_W'({scc_pkg::RADIUS_W{1'b1}});
         out_in.res_x           = rq.coord_x;
         out_in.res_y           = rq.coord_y;
         out_in.res_z           = rq.coord_z;
         out_in.res_radius      = sat ? {scc_pkg::RADIUS_W{1'b1}} : nr[scc_pkg::RADIUS_W-1:0];
         out_in.res_horiz_angle = angle_out(h);
         out_in.res_vert_angle  = angle_out(v);
         if (sat) out_in.status = scc_pkg::STATUS_SAT;
         else if (undef) out_in.status = scc_pkg::STATUS_UNDEF;
         else out_in.status = scc_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= g2_valid;
      end
      out_ff <= out_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

// ===== hw/rtl/scc_cordic_stage.sv =====
// one registered cordic micro-rotation, vectoring or rotating by item mode
module scc_cordic_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [scc_pkg::IDX_W-1:0]   stage_idx,
   input  logic                        in_valid,
   input  scc_pkg::scc_data_type       in_data,
   output logic                        out_valid,
   output scc_pkg::scc_data_type       out_data
);

   logic                  valid_ff;
   scc_pkg::scc_data_type data_ff;
   scc_pkg::scc_data_type data_in;
   logic signed [scc_pkg::LEN_W-1:0] dx;
   logic signed [scc_pkg::LEN_W-1:0] dy;
   logic signed [scc_pkg::ANG_W-1:0] step_ang;
   logic                             ccw;

   always_comb begin
      dx       = in_data.y >>> stage_idx;
      dy       = in_data.x >>> stage_idx;
      step_ang = scc_pkg::atan_q32(stage_idx);
      // rotation follows the residual angle, vectoring drives y to zero
      if (in_data.side.req.req_type == scc_pkg::MODE_TO_CART) begin
         ccw = ~in_data.ang[scc_pkg::ANG_W-1];
      end else begin
         ccw = in_data.y[scc_pkg::LEN_W-1];
      end
      data_in = in_data;
      if (ccw) begin
         data_in.x   = in_data.x - dx;
         data_in.y   = in_data.y + dy;
         data_in.ang = in_data.ang - step_ang;
      end else begin
         data_in.x   = in_data.x + dx;
         data_in.y   = in_data.y - dy;
         data_in.ang = in_data.ang + step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/scc_gain.sv =====
// three-stage cordic gain correction on both length lanes, rounding to nearest
module scc_gain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  scc_pkg::scc_data_type in_data,
   output logic                  out_valid,
   output scc_pkg::scc_data_type out_data
);

   localparam int PROD_W = 32 + scc_pkg::GAIN_W;

   logic [2:0] valid_ff;

   // magnitude stage
   scc_pkg::scc_data_type       a_data_ff;
   logic [scc_pkg::LEN_W-1:0]   a_mag_x_ff, a_mag_y_ff, a_mag_x_in, a_mag_y_in;
   logic                        a_neg_x_ff, a_neg_y_ff;

   // product stage
   scc_pkg::scc_data_type b_data_ff;
   logic [PROD_W-1:0]     b_hx_ff, b_lx_ff, b_hy_ff, b_ly_ff;
   logic                  b_neg_x_ff, b_neg_y_ff;

   // combine stage
   scc_pkg::scc_data_type c_data_ff, c_data_in;
   logic [scc_pkg::LEN_W-1:0] sum_x, sum_y;

   always_comb begin
      a_mag_x_in = in_data.x[scc_pkg::LEN_W-1] ? unsigned'(-in_data.x) : unsigned'(in_data.x);
      a_mag_y_in = in_data.y[scc_pkg::LEN_W-1] ? unsigned'(-in_data.y) : unsigned'(in_data.y);
   end

   always_comb begin
      sum_x = (scc_pkg::LEN_W'(b_hx_ff) << 2)
            + ((scc_pkg::LEN_W'(b_lx_ff) + (64'd1 << 29)) >> 30);
      sum_y = (scc_pkg::LEN_W'(b_hy_ff) << 2)
            + ((scc_pkg::LEN_W'(b_ly_ff) + (64'd1 << 29)) >> 30);
      c_data_in   = b_data_ff;
      c_data_in.x = b_neg_x_ff ? -signed'(sum_x) : signed'(sum_x);
      c_data_in.y = b_neg_y_ff ? -signed'(sum_y) : signed'(sum_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
      a_data_ff  <= in_data;
      a_mag_x_ff <= a_mag_x_in;
      a_mag_y_ff <= a_mag_y_in;
      a_neg_x_ff <= in_data.x[scc_pkg::LEN_W-1];
      a_neg_y_ff <= in_data.y[scc_pkg::LEN_W-1];

      b_data_ff  <= a_data_ff;
      b_hx_ff    <= PROD_W'(a_mag_x_ff[63:32]) * PROD_W'(scc_pkg::INV_GAIN);
      b_lx_ff    <= PROD_W'(a_mag_x_ff[31:0]) * PROD_W'(scc_pkg::INV_GAIN);
      b_hy_ff    <= PROD_W'(a_mag_y_ff[63:32]) * PROD_W'(scc_pkg::INV_GAIN);
      b_ly_ff    <= PROD_W'(a_mag_y_ff[31:0]) * PROD_W'(scc_pkg::INV_GAIN);
      b_neg_x_ff <= a_neg_x_ff;
      b_neg_y_ff <= a_neg_y_ff;

      c_data_ff  <= c_data_in;
   end

   assign out_valid = valid_ff[2];
   assign out_data  = c_data_ff;

endmodule

// ===== bench/tb_spherical_coord_converter_core.sv =====
// testbench for the spherical coordinate converter: directed and random items, scoreboard check
`timescale 1ns / 1ps

module tb_spherical_coord_converter_core;
   import scc_pkg::*;

   localparam longint unsigned MASK32   = 64'hFFFF_FFFF;
   localparam longint unsigned GAIN_Q30 = 64'd652032874;
   localparam longint          PI_L     = 64'sh3243F6A89;
   localparam longint          HPI_L    = 64'sh1921FB544;
   localparam longint          TPI_L    = 64'sh6487ED511;
   localparam int              SHIFT_G  = 60 - COORD_W;

   class conversion_scoreboard;
      scc_rsp_type pending_q[$];
      int          mismatches = 0;

      function longint atan_step(int i);
         case (i)
            0:  return 64'sd3373259426;
            1:  return 64'sd1991351318;
            2:  return 64'sd1052175346;
            3:  return 64'sd534100635;
            4:  return 64'sd268086748;
            5:  return 64'sd134174063;
            6:  return 64'sd67103403;
            7:  return 64'sd33553749;
            8:  return 64'sd16777131;
            9:  return 64'sd8388597;
            10: return 64'sd4194303;
            default: return (i <= 32) ? (64'sd1 <<< (32 - i)) : 64'sd0;
         endcase
      endfunction

      // round(a / K) with the endless-cordic gain in Q30
      function longint unsigned unscale(longint unsigned a);
         longint unsigned hi, lo;
         hi = a >> 32;
         lo = a & MASK32;
         return hi * GAIN_Q30 * 4 + ((lo * GAIN_Q30 + (64'd1 << 29)) >> 30);
      endfunction

      function longint unscale_s(longint v);
         if (v < 0) return -longint'(unscale(longint'(-v)));
         return longint'(unscale(v));
      endfunction

      function longint vectoring(inout longint px, inout longint py);
         longint x, y, ang, dx, dy;
         x = px; y = py; ang = 0;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; ang += atan_step(i);
            end else begin
               x -= dx; y += dy; ang -= atan_step(i);
            end
         end
         px = x; py = y;
         return ang;
      endfunction

      function void rotation(inout longint px, inout longint py, input longint ang);
         longint x, y, dx, dy;
         x = px; y = py;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
               x -= dx; y += dy; ang -= atan_step(i);
            end else begin
               x += dx; y -= dy; ang += atan_step(i);
            end
         end
         px = x; py = y;
      endfunction

      // into [-pi/2, pi/2]; returns 1 when the vector has to be flipped
      function bit fold(inout longint a);
         bit flip;
         flip = 0;
         if (a >= PI_L) a -= TPI_L;
         if (a < -PI_L) a += TPI_L;
         if (a > HPI_L) begin
            a -= PI_L; flip = 1;
         end else if (a < -HPI_L) begin
            a += PI_L; flip = 1;
         end
         return flip;
      endfunction

      function longint clamp_hpi(longint a);
         if (a > HPI_L) return HPI_L;
         if (a < -HPI_L) return -HPI_L;
         return a;
      endfunction

      function logic [31:0] to_q28(longint a);
         return 32'((a + 8) >>> 4);
      endfunction

      function logic [COORD_W-1:0] to_coord(longint v, inout bit sat);
         longint lim, r;
         lim = 64'sd1 <<< (COORD_W - 1);
         r = (v + (64'sd1 <<< (SHIFT_G - 1))) >>> SHIFT_G;
         if (r > lim - 1) begin
            r = lim - 1; sat = 1;
         end
         if (r < -lim) begin
            r = -lim; sat = 1;
         end
         return COORD_W'(r);
      endfunction

      function scc_rsp_type convert(scc_req_type q);
         scc_rsp_type e;
         longint x, y, z, a, b, h, m, c, v, r, ha, va, cx, cy, px, pz;
         longint unsigned nr, rmax;
         bit sat, undef, nv, nh;
         sat = 0;
         rmax = (64'd1 << (COORD_W - 1)) - 1;
         if (q.req_type == MODE_TO_POLAR) begin
            x = q.coord_x; y = q.coord_y; z = q.coord_z;
            a = (x < 0) ? -x <<< SHIFT_G : x <<< SHIFT_G;
            b = (x < 0) ? -z <<< SHIFT_G : z <<< SHIFT_G;
            h = vectoring(a, b);
            m = longint'(unscale(a));
            c = y <<< SHIFT_G;
            v = vectoring(m, c);
            nr = (unscale(m) + (64'd1 << (SHIFT_G - 1))) >> SHIFT_G;
            undef = (x == 0 && z == 0);
            if (x == 0) h = (z > 0) ? HPI_L : (z < 0) ? -HPI_L : 0;
            else begin
               h = clamp_hpi(h);
               if (x < 0) h += PI_L;
            end
            if (undef) v = (y > 0) ? HPI_L : (y < 0) ? -HPI_L : 0;
            else v = clamp_hpi(v);
            if (nr > rmax) begin
               nr = rmax; sat = 1;
            end
            e.res_x = q.coord_x;
            e.res_y = q.coord_y;
            e.res_z = q.coord_z;
            e.res_radius = RADIUS_W'(nr);
            e.res_horiz_angle = to_q28(h);
            e.res_vert_angle = to_q28(v);
            e.status = sat ? STATUS_SAT : (undef ? STATUS_UNDEF : STATUS_OK);
         end else begin
            r = longint'(q.radius) <<< SHIFT_G;
            ha = longint'(q.horiz_angle) * 16;
            va = longint'(q.vert_angle) * 16;
            nv = fold(va);
            nh = fold(ha);
            cx = nv ? -r : r;
            cy = 0;
            rotation(cx, cy, va);
            px = unscale_s(cx);
            if (nh) px = -px;
            pz = 0;
            rotation(px, pz, ha);
            e.res_x = to_coord(unscale_s(px), sat);
            e.res_y = to_coord(unscale_s(cy), sat);
            e.res_z = to_coord(unscale_s(pz), sat);
            e.res_radius = q.radius;
            e.res_horiz_angle = q.horiz_angle;
            e.res_vert_angle = q.vert_angle;
            e.status = sat ? STATUS_SAT : STATUS_OK;
         end
         return e;
      endfunction

      function void note(scc_req_type q);
         pending_q.push_back(convert(q));
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         mismatches++;
      endtask

      task check(scc_rsp_type got);
         scc_rsp_type e;
         if (pending_q.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         e = pending_q.pop_front();
         if (got.res_x !== e.res_x) report("res_x", got.res_x, e.res_x);
         if (got.res_y !== e.res_y) report("res_y", got.res_y, e.res_y);
         if (got.res_z !== e.res_z) report("res_z", got.res_z, e.res_z);
         if (got.res_radius !== e.res_radius) report("res_radius", got.res_radius, e.res_radius);
         if (got.res_horiz_angle !== e.res_horiz_angle)
            report("res_horiz_angle", got.res_horiz_angle, e.res_horiz_angle);
         if (got.res_vert_angle !== e.res_vert_angle)
            report("res_vert_angle", got.res_vert_angle, e.res_vert_angle);
         if (got.status !== e.status) report("status", got.status, e.status);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   scc_req_type req_item = '0;
   logic        rsp_valid;
   scc_rsp_type rsp_item;

   conversion_scoreboard sb = new();

   spherical_coord_converter_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_item);
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

   task send_item(scc_req_type q, int gap);
      start <= 1'b1;
      req_item <= q;
      do @(posedge clock); while (busy);
      sb.note(q);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random value with a random magnitude so small and large values both show up
   function logic [31:0] spread32();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: v = v >>> $urandom_range(0, 31);
         1: v = $signed(v) >>> $urandom_range(0, 31);
         default: ;
      endcase
      return v;
   endfunction

   function scc_req_type make_item(logic mode, longint a, longint b, longint c,
                                   longint r, longint h, longint v);
      scc_req_type q;
      q.req_type = mode;
      q.coord_x = COORD_W'(a); q.coord_y = COORD_W'(b); q.coord_z = COORD_W'(c);
      q.radius = RADIUS_W'(r); q.horiz_angle = ANG_IO_W'(h); q.vert_angle = ANG_IO_W'(v);
      return q;
   endfunction

   initial begin
      scc_req_type q;
      int gap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero vector, axes, saturating norm, angle extremes
      send_item(make_item(MODE_TO_POLAR, 0, 0, 0, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, 0, 5, 0, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, 0, -5, 0, 0, 0, 0), 1);
      send_item(make_item(MODE_TO_POLAR, 0, 7, 65536, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, 0, -7, -65536, 0, 0, 0), 2);
      send_item(make_item(MODE_TO_POLAR, -65536, 0, 65536, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, -65536, 0, -65536, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, -1, -1), 3);
      send_item(make_item(MODE_TO_POLAR, 1, -1, 1, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_POLAR, -1, 0, 0, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 0, 0, 0), 0);
      send_item(make_item(MODE_TO_CART, -1, -1, -1, 31'h7FFF_FFFF, 0, 0), 0);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF), 1);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000), 0);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 65536, 32'h1921_FB54, 0), 0);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 65536, 0, 32'h1921_FB54), 0);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 65536, 32'h3243_F6A9, 32'hCDBC_0957), 0);
      send_item(make_item(MODE_TO_CART, 0, 0, 0, 65536, 32'h6487_ED51, 32'h9B78_12AF), 4);

      for (int n = 0; n < 450; n++) begin
         q.req_type = 1'($urandom_range(0, 1));
         q.coord_x = ($urandom_range(0, 9) == 0) ? 32'd0 : spread32();
         q.coord_y = spread32();
         q.coord_z = ($urandom_range(0, 9) == 0) ? 32'd0 : spread32();
         q.radius = RADIUS_W'(spread32());
         q.horiz_angle = spread32();
         q.vert_angle = spread32();
         // stretches of back-to-back items between spells of random gaps
         gap = ((n / 40) % 2 == 0) ? $urandom_range(0, 8) : 0;
         send_item(q, gap);
         if (n == 200) begin
            start <= 1'b0;
            while (sb.pending_q.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      if (sb.mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/scc_pkg.sv
hw/rtl/scc_cordic_stage.sv
hw/rtl/scc_gain.sv
hw/rtl/spherical_coord_converter_core.sv
bench/tb_spherical_coord_converter_core.sv
